[rtl/kfnf_pkg.sv]
// kfnf_pkg: shared constants, register indexes and the command type that
// travels from the front control to the back pipeline of the noise filter.
// No dependencies.
package kfnf_pkg;

    // default sizes
    localparam int WINDOW_DEF    = 4;
    localparam int MAX_WIDTH_DEF = 2048;

    // field and counter widths
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;
    localparam int POS_W  = 24;
    localparam int COL_W  = 12;
    localparam int SLOT_W = 4;
    localparam int PRE_W  = 3;

    // pixel byte that counts as on
    localparam logic [PIX_W-1:0] PIX_ON = 8'hFF;

    // register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // register reset values
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // one command per accepted item
    typedef struct packed {
        logic              wr_en;
        logic              wr_bit;
        logic [COL_W-1:0]  wr_col;
        logic [SLOT_W-1:0] wr_slot;
        logic              emit;
        logic              win_mode;
        logic              rd_shift;
        logic              rd_start;
        logic [COL_W-1:0]  rd_col;
        logic [SLOT_W-1:0] rd_base;
        logic [PRE_W-1:0]  pre_idx;
        logic [COL_W-1:0]  pass_col;
        logic [SLOT_W-1:0] pass_slot;
    } kfnf_cmd_t;

endpackage

[rtl/kfill_binary_noise_filter.sv]
// kfill_binary_noise_filter: kFill salt-and-pepper filter on a binary pixel stream.
// Items pass the command queue, stage one, stage two and the output register.
// Throughput: one item per cycle unless the output stalls, set by the single
// write and two column reads of the line store per item; the output pixel lags
// the input by (WINDOW-2)*width + WINDOW-1 items; flush items drain the frame tail.
// Reset: synchronous active-low aresetn clears counters and valids; no store clearing.
module kfill_binary_noise_filter #(
    parameter int WINDOW    = kfnf_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH = kfnf_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [kfnf_pkg::PIX_W-1:0]  s_pixel,
    input  logic                        s_flush,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_out_valid,
    output logic                        m_out_pixel,
    input  logic                        cfg_wr_en,
    input  logic [kfnf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [kfnf_pkg::CFG_W-1:0]  cfg_data
);
    import kfnf_pkg::*;

    logic      q_push, q_full, q_pop, q_valid;
    kfnf_cmd_t push_cmd, head_cmd;

    // front: accept and classify
    kfnf_ctrl #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .s_flush   (s_flush),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // command queue
    kfnf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_cmd    (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_cmd   (head_cmd)
    );

    // back: store, window and decision
    kfnf_back #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_valid (m_out_valid),
        .m_out_pixel (m_out_pixel)
    );

endmodule

[rtl/kfnf_ctrl.sv]
// kfnf_ctrl: front part; accepts items, holds the frame registers and the
// input and output position counters, and builds one command per item.
// Depends on kfnf_pkg.
module kfnf_ctrl #(
    parameter int WINDOW    = kfnf_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH = kfnf_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [kfnf_pkg::PIX_W-1:0]  s_pixel,
    input  logic                        s_flush,
    input  logic                        cfg_wr_en,
    input  logic [kfnf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [kfnf_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        q_full,
    output logic                        q_push,
    output kfnf_pkg::kfnf_cmd_t         q_cmd
);
    import kfnf_pkg::*;

    localparam int SLOTS   = 2 * WINDOW - 1;
    localparam int W_CLAMP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam int RST_W   = (RESET_WIDTH > W_CLAMP) ? W_CLAMP : RESET_WIDTH;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    logic [CFG_W-1:0]  w_reg, w_next, h_reg, h_next;
    logic [POS_W-1:0]  total_reg, total_next, need_reg, need_next;
    logic              win_ok_reg, win_ok_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [POS_W-1:0]  lead_reg, lead_next;
    logic [POS_W-1:0]  epos_reg, epos_next;
    logic [CFG_W-1:0]  erow_reg, erow_next;
    logic [COL_W-1:0]  ecol_reg, ecol_next;
    logic [SLOT_W-1:0] eslot_reg, eslot_next;

    logic              cfg_hit;
    logic [CFG_W-1:0]  w_new, h_new, w_use, h_use;
    logic [POS_W-1:0]  lead_inc, rem, need_eff;
    logic              emit, win_mode, shift;
    logic [COL_W:0]    j, jw, col_sel;
    logic [CFG_W:0]    erow_inc, row_b, rb_w, k_wide;
    logic [SLOT_W-1:0] eslot_inc, slot_b;
    logic [SLOT_W:0]   k_s, base_wide;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // register writes
    always_comb begin
        cfg_hit = cfg_wr_en &&
                  (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
        if (cfg_data == '0) begin
            w_new = CFG_W'(1);
            h_new = CFG_W'(1);
        end else begin
            w_new = (cfg_data > CFG_W'(W_CLAMP)) ? CFG_W'(W_CLAMP) : cfg_data;
            h_new = cfg_data;
        end
        w_use = (cfg_index == REG_IMAGE_WIDTH)  ? w_new : w_reg;
        h_use = (cfg_index == REG_IMAGE_HEIGHT) ? h_new : h_reg;
    end

    // emit decision for the current item
    always_comb begin
        lead_inc = lead_reg + {{(POS_W-1){1'b0}}, ~s_flush};
        rem      = total_reg - epos_reg;
        need_eff = (rem < need_reg) ? rem : need_reg;
        emit     = (lead_inc != '0) && (lead_inc >= need_eff);
        win_mode = win_ok_reg && (ecol_reg != '0) &&
                   ({1'b0, ecol_reg} + (COL_W+1)'(2) <= {1'b0, w_reg}) &&
                   (erow_reg != '0) &&
                   ({1'b0, erow_reg} + (CFG_W+1)'(2) <= {1'b0, h_reg});
    end

    // column read address and row slot base of the window
    always_comb begin
        j       = {1'b0, ecol_reg} + (COL_W+1)'(WINDOW - 2);
        shift   = j < {1'b0, w_reg};
        jw      = j - {1'b0, w_reg};
        col_sel = shift ? j : jw;
        erow_inc  = {1'b0, erow_reg} + (CFG_W+1)'(1);
        eslot_inc = (eslot_reg == SLOT_LAST) ? '0 : eslot_reg + SLOT_W'(1);
        if (shift) begin
            row_b  = {1'b0, erow_reg};
            slot_b = eslot_reg;
        end else begin
            row_b  = (erow_inc >= {1'b0, h_reg}) ? '0 : erow_inc;
            slot_b = eslot_inc;
        end
        rb_w = row_b + (CFG_W+1)'(WINDOW - 1);
        if (row_b == '0 || rb_w <= {1'b0, h_reg}) begin
            k_wide = (CFG_W+1)'(1);
        end else begin
            k_wide = rb_w + (CFG_W+1)'(1) - {1'b0, h_reg};
        end
        k_s = (k_wide > (CFG_W+1)'(SLOTS - 1)) ? (SLOT_W+1)'(SLOTS - 1)
                                                : k_wide[SLOT_W:0];
        if ({1'b0, slot_b} >= k_s) begin
            base_wide = {1'b0, slot_b} - k_s;
        end else begin
            base_wide = {1'b0, slot_b} + (SLOT_W+1)'(SLOTS) - k_s;
        end
    end

    // command for the back part
    always_comb begin
        q_cmd           = '0;
        q_cmd.wr_en     = !s_flush;
        q_cmd.wr_bit    = (s_pixel == PIX_ON);
        q_cmd.wr_col    = col_reg;
        q_cmd.wr_slot   = in_slot_reg;
        q_cmd.emit      = emit;
        q_cmd.win_mode  = win_mode;
        q_cmd.rd_shift  = shift;
        q_cmd.rd_start  = (ecol_reg == '0);
        q_cmd.rd_col    = (col_sel < (COL_W+1)'(MAX_WIDTH)) ? col_sel[COL_W-1:0] : '0;
        q_cmd.rd_base   = base_wide[SLOT_W-1:0];
        q_cmd.pre_idx   = jw[PRE_W-1:0];
        q_cmd.pass_col  = ecol_reg;
        q_cmd.pass_slot = eslot_reg;
    end

    // next state of registers and counters
    always_comb begin
        w_next       = w_reg;
        h_next       = h_reg;
        total_next   = total_reg;
        need_next    = need_reg;
        win_ok_next  = win_ok_reg;
        col_next     = col_reg;
        in_slot_next = in_slot_reg;
        lead_next    = lead_reg;
        epos_next    = epos_reg;
        erow_next    = erow_reg;
        ecol_next    = ecol_reg;
        eslot_next   = eslot_reg;
        if (cfg_hit) begin
            w_next       = w_use;
            h_next       = h_use;
            total_next   = POS_W'(w_use) * POS_W'(h_use);
            need_next    = POS_W'(w_use) * POS_W'(WINDOW - 2) + POS_W'(WINDOW - 1);
            win_ok_next  = (w_use >= CFG_W'(WINDOW)) && (h_use >= CFG_W'(WINDOW));
            col_next     = '0;
            in_slot_next = '0;
            lead_next    = '0;
            epos_next    = '0;
            erow_next    = '0;
            ecol_next    = '0;
            eslot_next   = '0;
        end else if (q_push) begin
            if (!s_flush) begin
                if (col_reg + COL_W'(1) >= w_reg) begin
                    col_next     = '0;
                    in_slot_next = (in_slot_reg == SLOT_LAST) ? '0
                                                              : in_slot_reg + SLOT_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            lead_next = lead_inc - POS_W'(emit);
            if (emit) begin
                epos_next = epos_reg + POS_W'(1);
                if (ecol_reg + COL_W'(1) >= w_reg) begin
                    ecol_next  = '0;
                    eslot_next = eslot_inc;
                    if (erow_inc >= {1'b0, h_reg}) begin
                        erow_next = '0;
                        epos_next = '0;
                    end else begin
                        erow_next = erow_inc[CFG_W-1:0];
                    end
                end else begin
                    ecol_next = ecol_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= CFG_W'(RST_W);
            h_reg       <= CFG_W'(RESET_HEIGHT);
            total_reg   <= POS_W'(RST_W * RESET_HEIGHT);
            need_reg    <= POS_W'((WINDOW - 2) * RST_W + WINDOW - 1);
            win_ok_reg  <= (RST_W >= WINDOW) && (RESET_HEIGHT >= WINDOW);
            col_reg     <= '0;
            in_slot_reg <= '0;
            lead_reg    <= '0;
            epos_reg    <= '0;
            erow_reg    <= '0;
            ecol_reg    <= '0;
            eslot_reg   <= '0;
        end else begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            total_reg   <= total_next;
            need_reg    <= need_next;
            win_ok_reg  <= win_ok_next;
            col_reg     <= col_next;
            in_slot_reg <= in_slot_next;
            lead_reg    <= lead_next;
            epos_reg    <= epos_next;
            erow_reg    <= erow_next;
            ecol_reg    <= ecol_next;
            eslot_reg   <= eslot_next;
        end
    end

    // pending pixels never reach the output lag
    a_lead_below_need: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_reg < need_reg)
        else $error("pending pixel count reached the output lag");

    // output column stays inside the row
    a_ecol_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        ecol_reg < w_reg)
        else $error("output column beyond row width");

    // output position stays inside the frame
    a_epos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        epos_reg < total_reg)
        else $error("output position beyond frame size");

endmodule

[rtl/kfnf_queue.sv]
// kfnf_queue: two-entry command queue between the front control and the
// back pipeline. Depends on kfnf_pkg.
module kfnf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kfnf_pkg::kfnf_cmd_t in_cmd,
    output logic                full,
    input  logic                pop,
    output logic                out_valid,
    output kfnf_pkg::kfnf_cmd_t out_cmd
);
    import kfnf_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    kfnf_cmd_t          entry_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]       count_reg, count_next;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && out_valid)) begin
            count_next = count_reg + (QAW+1)'(1);
        end else if (!push && pop && out_valid) begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop && out_valid) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/kfnf_back.sv]
// kfnf_back: back pipeline; line store, window and preload registers,
// kFill decision and the output register. Depends on kfnf_pkg.
module kfnf_back #(
    parameter int WINDOW    = kfnf_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH = kfnf_pkg::MAX_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  kfnf_pkg::kfnf_cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_out_valid,
    output logic                m_out_pixel
);
    import kfnf_pkg::*;

    localparam int SLOTS     = 2 * WINDOW - 1;
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int SW        = $clog2(SLOTS);
    localparam int PDEPTH    = WINDOW - 2;
    localparam int PW        = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int RING      = 4 * (WINDOW - 1);
    localparam int CNT_W     = $clog2(RING + 1);
    localparam int CORE_W    = $clog2(PDEPTH * PDEPTH + 1);
    localparam int LIM       = 3 * WINDOW - 4;
    localparam int CORE_HALF = (PDEPTH * PDEPTH) / 2;

    // line store: one word per column, one bit per row slot
    logic [SLOTS-1:0]  mem [MAX_WIDTH];
    logic [SLOTS-1:0]  rd_a_reg, rd_b_reg;
    logic              byp_a_reg, byp_b_reg;
    logic              adv;
    logic [AW-1:0]     wa, ra, rb;

    logic              s1_valid_reg;
    kfnf_cmd_t         s1_cmd_reg;
    logic [SLOTS-1:0]  word_a, word_b;
    logic [WINDOW-1:0] col_bits;
    logic              pass_bit;

    logic [WINDOW-1:0] win_reg [WINDOW];
    logic [WINDOW-1:0] pre_reg [PDEPTH];

    logic              s2_valid_reg, s2_emit_reg, s2_mode_reg, s2_pass_reg;
    logic              m_valid_reg, m_out_valid_reg, m_out_pixel_reg;

    logic [RING-1:0]   ring;
    logic [CORE_W-1:0] core;
    logic [CNT_W-1:0]  up, down, on_ring, off_ring;
    logic [2:0]        c_on, c_off;
    logic              decision;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = q_valid && adv;
    assign wa    = q_cmd.wr_col[AW-1:0];
    assign ra    = q_cmd.rd_col[AW-1:0];
    assign rb    = q_cmd.pass_col[AW-1:0];

    // store write and registered reads
    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.wr_en) begin
            mem[wa][q_cmd.wr_slot[SW-1:0]] <= q_cmd.wr_bit;
        end
        if (adv) begin
            rd_a_reg <= mem[ra];
            rd_b_reg <= mem[rb];
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg <= q_cmd;
            byp_a_reg  <= q_cmd.wr_en && (wa == ra);
            byp_b_reg  <= q_cmd.wr_en && (wa == rb);
        end
    end

    // read data with forwarding of the pixel written by the same item
    always_comb begin
        logic [SW:0] sidx;
        sidx   = '0;
        word_a = rd_a_reg;
        word_b = rd_b_reg;
        if (byp_a_reg) begin
            word_a[s1_cmd_reg.wr_slot[SW-1:0]] = s1_cmd_reg.wr_bit;
        end
        if (byp_b_reg) begin
            word_b[s1_cmd_reg.wr_slot[SW-1:0]] = s1_cmd_reg.wr_bit;
        end
        for (int a = 0; a < WINDOW; a++) begin
            sidx = (SW+1)'(s1_cmd_reg.rd_base[SW-1:0]) + (SW+1)'(a);
            if (sidx >= (SW+1)'(SLOTS)) begin
                sidx = sidx - (SW+1)'(SLOTS);
            end
            col_bits[a] = word_a[sidx[SW-1:0]];
        end
        pass_bit = word_b[s1_cmd_reg.pass_slot[SW-1:0]];
    end

    // window shift, row start load, and preload of the next row
    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg && s1_cmd_reg.emit) begin
            if (s1_cmd_reg.rd_shift && s1_cmd_reg.rd_start) begin
                for (int i = 1; i < WINDOW - 1; i++) begin
                    win_reg[i] <= pre_reg[i-1];
                end
                win_reg[WINDOW-1] <= col_bits;
            end else if (s1_cmd_reg.rd_shift) begin
                for (int i = 0; i < WINDOW - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW-1] <= col_bits;
            end else begin
                pre_reg[s1_cmd_reg.pre_idx[PW-1:0]] <= col_bits;
            end
        end
    end

    // stage two payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_emit_reg <= s1_cmd_reg.emit;
            s2_mode_reg <= s1_cmd_reg.win_mode;
            s2_pass_reg <= pass_bit;
        end
    end

    // ring, core and corner counts of the window
    always_comb begin
        ring    = '0;
        core    = '0;
        up      = '0;
        down    = '0;
        on_ring = '0;
        c_on    = '0;
        c_off   = '0;
        for (int b = 0; b < WINDOW; b++) begin
            ring[b]              = win_reg[b][0];
            ring[3*WINDOW-3-b]   = win_reg[b][WINDOW-1];
        end
        for (int a = 1; a < WINDOW - 1; a++) begin
            ring[4*WINDOW-4-a] = win_reg[0][a];
            ring[WINDOW-1+a]   = win_reg[WINDOW-1][a];
            for (int b = 1; b < WINDOW - 1; b++) begin
                core = core + CORE_W'(win_reg[b][a]);
            end
        end
        for (int i = 0; i < RING; i++) begin
            if (!ring[i] && ring[(i+1)%RING]) begin
                up = up + CNT_W'(1);
            end else if (ring[i] && !ring[(i+1)%RING]) begin
                down = down + CNT_W'(1);
            end
            on_ring = on_ring + CNT_W'(ring[i]);
            if (i % (WINDOW - 1) == 0) begin
                c_on  = c_on + 3'(ring[i]);
                c_off = c_off + 3'(!ring[i]);
            end
        end
        off_ring = CNT_W'(RING) - on_ring;
        if (core >= CORE_W'(CORE_HALF)) begin
            decision = !((up == CNT_W'(1)) &&
                         ((off_ring > CNT_W'(LIM)) ||
                          (off_ring == CNT_W'(LIM) && c_off == 3'd2)));
        end else begin
            decision = (down == CNT_W'(1)) &&
                       ((on_ring > CNT_W'(LIM)) ||
                        (on_ring == CNT_W'(LIM) && c_on == 3'd2));
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_out_valid_reg <= s2_emit_reg;
            m_out_pixel_reg <= s2_emit_reg && (s2_mode_reg ? decision : s2_pass_reg);
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_valid = m_out_valid_reg;
    assign m_out_pixel = m_out_pixel_reg;

    // a result without a pixel carries an off pixel
    a_idle_result_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_out_valid_reg |-> !m_out_pixel_reg)
        else $error("pixel set on a result without a pixel");

endmodule

[dv/kfill_binary_noise_filter_tb.sv]
// kfill_binary_noise_filter_tb: self-checking testbench for the kFill noise filter.
// Holds a bit-accurate predictor of the filter, drives frames of binary images
// with random idling and backpressure, and checks every result in order.
// Depends on kfnf_pkg and kfill_binary_noise_filter.
module kfill_binary_noise_filter_tb;
    import kfnf_pkg::*;

    localparam int WIN      = WINDOW_DEF;
    localparam int MAXW     = MAX_WIDTH_DEF;
    localparam int SLOTS    = 2 * WIN - 1;
    localparam int RING_LEN = 4 * (WIN - 1);
    localparam int STALL_LIMIT = 4000;
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        bit out_valid;
        bit out_pixel;
    } filt_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [PIX_W-1:0] s_pixel = '0;
    logic             s_flush = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_out_valid;
    logic             m_out_pixel;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    kfill_binary_noise_filter dut (.*);

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0] width_reg = RESET_WIDTH;
    logic [CFG_W-1:0] height_reg = RESET_HEIGHT;
    bit               row_mem [SLOTS][MAXW];
    int unsigned      in_col, in_row, in_slot;
    int unsigned      out_pos, out_row, out_col, out_slot, backlog;

    filt_result_t expected_pixels[$];
    int  error_count = 0;
    int  items_sent = 0;
    int  frames_sent = 0;
    int  pixels_emitted = 0;
    int  idle_count = 0;
    bit  tx_quiet = 0;
    bit  rx_quiet = 0;
    int  hold_cycles = 0;

    function automatic int unsigned eff_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function automatic void restart_stream();
        in_col = 0; in_row = 0; in_slot = 0;
        out_pos = 0; out_row = 0; out_col = 0; out_slot = 0;
        backlog = 0;
    endfunction

    function automatic bit fill_holds(int steps, int n, int corners);
        int lim;
        lim = 3 * WIN - 4;
        return steps == 1 && (n > lim || (n == lim && corners == 2));
    endfunction

    // kfill decision of the window with top-left corner (ty, tx)
    function automatic bit window_decision(int unsigned ty, int unsigned tx);
        bit ring [RING_LEN];
        int core, on_ring, up, down, c_on, c_off;
        int unsigned slot;
        bit v, cur, nxt;
        core = 0; on_ring = 0; up = 0; down = 0; c_on = 0; c_off = 0;
        for (int a = 0; a < WIN; a++) begin
            slot = (out_slot + SLOTS + ty + a - out_row) % SLOTS;
            for (int b = 0; b < WIN; b++) begin
                v = row_mem[slot][(tx + b) % MAXW];
                if (a == 0) ring[b] = v;
                else if (a == WIN - 1) ring[3 * WIN - 3 - b] = v;
                else if (b == 0) ring[4 * WIN - 4 - a] = v;
                else if (b == WIN - 1) ring[WIN - 1 + a] = v;
                else core += v;
            end
        end
        // walk the closed ring
        for (int a = 0; a < RING_LEN; a++) begin
            cur = ring[a];
            nxt = ring[(a + 1) % RING_LEN];
            if (cur < nxt) up++;
            else if (cur > nxt) down++;
            if (cur) on_ring++;
            if (a % (WIN - 1) == 0) begin
                if (cur) c_on++; else c_off++;
            end
        end
        if (core >= ((WIN - 2) * (WIN - 2)) / 2)
            return fill_holds(up, RING_LEN - on_ring, c_off) ? 1'b0 : 1'b1;
        return fill_holds(down, on_ring, c_on) ? 1'b1 : 1'b0;
    endfunction

    // advance the predictor by one accepted item
    function automatic filt_result_t predict_filtered(logic [PIX_W-1:0] pix, logic fl);
        int unsigned w, h, total, need, rem, ty, tx;
        filt_result_t res;
        w = eff_width();
        h = eff_height();
        total = w * h;
        need = (WIN - 2) * w + (WIN - 1);
        res = '{0, 0};
        if (!fl) begin
            row_mem[in_slot % SLOTS][in_col % MAXW] = (pix == PIX_ON);
            backlog++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_slot = (in_slot + 1) % SLOTS;
                in_row++;
                if (in_row >= h) in_row = 0;
            end
        end
        rem = (out_pos < total) ? total - out_pos : 0;
        if (rem < need) need = rem;
        if (backlog == 0 || backlog < need) return res;
        res.out_valid = 1'b1;
        if (w >= WIN && h >= WIN && out_col >= 1 && out_col + 2 <= w &&
            out_row >= 1 && out_row + 2 <= h) begin
            ty = out_row - 1;
            tx = out_col - 1;
            if (ty > h - WIN) ty = h - WIN;
            if (tx > w - WIN) tx = w - WIN;
            res.out_pixel = window_decision(ty, tx);
        end else begin
            res.out_pixel = row_mem[out_slot % SLOTS][out_col % MAXW];
        end
        backlog--;
        out_pos++;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_slot = (out_slot + 1) % SLOTS;
            out_row++;
            if (out_row >= h) begin
                out_row = 0;
                out_pos = 0;
            end
        end
        return res;
    endfunction

    // offer one item, wait for acceptance, then record the expected result
    task automatic send_item(logic [PIX_W-1:0] pix, logic fl);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        s_flush <= fl;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.insert(expected_pixels.size(), predict_filtered(pix, fl));
        items_sent++;
    endtask

    task automatic send_flushes(int n);
        repeat (n) send_item($urandom_range(0, 255), 1'b1);
    endtask

    // drain everything, then let the pipeline settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = data;
            restart_stream();
        end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = data;
            restart_stream();
        end
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // striped image with salt-and-pepper noise; off pixels sometimes carry junk bytes
    task automatic send_frame(int noise_pct, int flush_pct);
        int unsigned w, h;
        bit on;
        logic [PIX_W-1:0] pix;
        w = eff_width();
        h = eff_height();
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                if ($urandom_range(0, 99) < flush_pct) send_flushes(1);
                on = ((x / 3 + y / 2) % 2) != 0;
                if ($urandom_range(0, 99) < noise_pct) on = !on;
                if (on) pix = PIX_ON;
                else if ($urandom_range(0, 3) == 0) pix = $urandom_range(0, 254);
                else pix = 8'h00;
                send_item(pix, 1'b0);
            end
        end
        frames_sent++;
    endtask

    // 4x4 frame from a bit pattern, row 0 in the low bits
    task automatic send_pattern(logic [15:0] pat);
        for (int i = 0; i < 16; i++) send_item(pat[i] ? PIX_ON : 8'h00, 1'b0);
        frames_sent++;
    endtask

    // receiver with random stalls and one requested long hold-off
    initial begin
        int stall;
        repeat (6) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        filt_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected item: out_valid=%0b out_pixel=%0b",
                       m_out_valid, m_out_pixel);
                error_count++;
            end else begin
                exp_res = expected_pixels.pop_front();
                if (m_out_valid !== exp_res.out_valid) begin
                    $error("out_valid mismatch: expected %0b actual %0b",
                           exp_res.out_valid, m_out_valid);
                    error_count++;
                end
                if (m_out_pixel !== exp_res.out_pixel) begin
                    $error("out_pixel mismatch: expected %0b actual %0b",
                           exp_res.out_pixel, m_out_pixel);
                    error_count++;
                end
                if (exp_res.out_valid) pixels_emitted++;
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // default registers: only flushes and early pixels, nothing emitted yet
    task automatic test_reset_defaults();
        send_flushes(3);
        send_item(PIX_ON, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h00, 1'b0);
        send_flushes(2);
    endtask

    // smallest full window: core fills, isolated noise, solid frames
    task automatic test_window_patterns();
        set_size(4, 4);
        send_pattern(16'h0000);
        send_flushes(11);
        send_pattern(16'h0020);   // single on pixel in the core
        send_flushes(11);
        send_pattern(16'hFFDF);   // single off pixel in the core
        send_flushes(11);
        send_pattern(16'hFFFF);
        send_flushes(11);
        send_pattern(16'h0F71);   // partial fill with corners
        send_flushes(11);
    endtask

    // frames smaller than the window, clamped sizes and unused register indexes
    task automatic test_tiny_frames();
        set_size(3, 3);
        send_frame(30, 0);
        send_flushes(10);
        set_size(0, 0);
        send_frame(50, 0);
        send_flushes(3);
        set_size(2, 5);
        send_frame(50, 0);
        send_flushes(8);
        write_reg(REG_SPARE_A, 12'hFFF);
        write_reg(REG_SPARE_B, 12'h000);
        send_frame(50, 0);
        send_flushes(8);
    endtask

    // largest sizes as partial frames, both sides without idling
    task automatic test_extreme_sizes();
        tx_quiet = 1;
        rx_quiet = 1;
        set_size(12'hFFF, 4);
        repeat (200) send_item(($urandom_range(0, 1) != 0) ? PIX_ON : 8'h00, 1'b0);
        send_flushes(2);
        set_size(3, 12'hFFF);
        repeat (120) send_item(($urandom_range(0, 1) != 0) ? PIX_ON : 8'h00, 1'b0);
        send_flushes(9);
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_size(16, 8);
        tx_quiet = 1;
        hold_cycles = 600;
        send_frame(10, 0);
        send_flushes(35);
        tx_quiet = 0;
    endtask

    // random sizes, back-to-back frames with partial drains and stray flushes
    task automatic test_random_frames();
        int start;
        int nframes;
        int unsigned w;
        start = items_sent;
        while (items_sent - start < 300) begin
            if ($urandom_range(0, 11) == 0)
                set_size($urandom_range(0, 5), $urandom_range(0, 6));
            else
                set_size($urandom_range(3, 24), $urandom_range(3, 10));
            w = eff_width();
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
                send_frame($urandom_range(0, 20), $urandom_range(0, 1) * 3);
                if (f == nframes - 1) send_flushes(2 * w + 3 + $urandom_range(0, 2));
                else send_flushes($urandom_range(0, 2 * w + 5));
            end
            // sometimes stop part way into a frame before the next restart
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 20)) send_item($urandom_range(0, 255), 1'b0);
        end
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_window_patterns();
        test_tiny_frames();
        test_backpressure();
        test_extreme_sizes();
        test_random_frames();
        wait_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d items in %0d frames, %0d filtered pixels emitted",
                 items_sent, frames_sent, pixels_emitted);
        $display("sizes from clamped minimum to clamped maximum, with stalls and hold-off");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
